[src/cmdl_pkg.sv]
// Shared types and constants for the text command line decoder.
// No dependencies; imported by every module of the block.
package cmdl_pkg;

    localparam int LINE_BYTES = 256;
    localparam int CNT_W      = $clog2(LINE_BYTES);
    localparam int NUM_KEYS   = 10;
    localparam int DIGIT_KEYS = 9;
    localparam int NUM_ACT    = 6;

    // keyword tracker slots
    localparam int KEY_A    = 0;
    localparam int KEY_AUTO = 1;
    localparam int KEY_AO   = 2;
    localparam int KEY_F    = 3;
    localparam int KEY_P    = 4;
    localparam int KEY_H    = 5;
    localparam int KEY_HE   = 6;
    localparam int KEY_L    = 7;
    localparam int KEY_LI   = 8;
    localparam int KEY_O    = 9;

    // actuator slots
    localparam int ACT_AUTO   = 0;
    localparam int ACT_FAN    = 1;
    localparam int ACT_PUMP   = 2;
    localparam int ACT_HEATER = 3;
    localparam int ACT_LIGHT  = 4;
    localparam int ACT_ALARM  = 5;

    // configuration register indexes
    localparam logic [7:0] REG_SHORT_GAP = 8'd0;
    localparam logic [7:0] REG_LONG_GAP  = 8'd1;

    localparam logic [7:0] SHORT_GAP_RESET = 8'd10;
    localparam logic [7:0] LONG_GAP_RESET  = 8'd100;

    localparam logic      CMD_BYTE = 1'b0;
    localparam logic      CMD_TICK = 1'b1;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ZERO = "0";
    localparam logic [7:0] CH_NINE = "9";
    localparam logic [7:0] CH_A    = "A";
    localparam logic [7:0] CH_E    = "E";
    localparam logic [7:0] CH_F    = "F";
    localparam logic [7:0] CH_H    = "H";
    localparam logic [7:0] CH_I    = "I";
    localparam logic [7:0] CH_L    = "L";
    localparam logic [7:0] CH_O    = "O";
    localparam logic [7:0] CH_P    = "P";
    localparam logic [7:0] CH_T    = "T";
    localparam logic [7:0] CH_U    = "U";
    localparam logic [7:0] CH_Z    = "Z";
    localparam logic [7:0] CH_LA   = "a";
    localparam logic [7:0] CH_LZ   = "z";

    localparam logic [3:0] LEVEL_ON  = 4'd1;
    localparam logic [3:0] LEVEL_OFF = 4'd0;

    // "AUTO" word progress
    typedef enum logic [1:0] {
        AW_NONE = 2'd0,
        AW_A    = 2'd1,
        AW_AU   = 2'd2,
        AW_AUT  = 2'd3
    } auto_word_t;

    // snapshot of the line trackers handed to the decoder
    typedef struct packed {
        logic                                any_kept;
        logic [NUM_KEYS-1:0]                 seen;
        logic [DIGIT_KEYS-1:0]               found;
        logic [DIGIT_KEYS-1:0][3:0]          value;
    } line_keys_t;

    typedef struct packed {
        logic       frame_timed_out;
        logic       text_empty;
        logic       ignored_in_auto;
        logic [NUM_ACT-1:0][3:0] levels;
    } frame_result_t;

endpackage

[src/cmdl_tracker.sv]
// Line framing and keyword tracking: byte count, line end, idle gap timer,
// and the per-keyword seen/digit trackers. Depends on cmdl_pkg.
module cmdl_tracker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic                 cmd,
    input  logic [7:0]           rx_byte,
    input  logic [7:0]           short_gap,
    input  logic [7:0]           long_gap,
    output logic                 fire,
    output logic                 timed_out,
    output cmdl_pkg::line_keys_t keys
);
    import cmdl_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             line_end_reg, line_end_next;
    logic [7:0]       idle_reg, idle_next;
    logic             cut_reg, cut_next;
    logic [7:0]       prev_reg, prev_next;
    auto_word_t       aw_reg, aw_next;
    line_keys_t       keys_reg, keys_next;

    logic is_digit, is_alpha, has_room, kept, idle_inc_ovf;
    logic [7:0] idle_inc;

    assign keys = keys_reg;

    always_comb begin
        is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
        is_alpha = ((rx_byte >= CH_A) && (rx_byte <= CH_Z)) ||
                   ((rx_byte >= CH_LA) && (rx_byte <= CH_LZ));
        has_room = count_reg < CNT_W'(LINE_BYTES - 1);
        kept     = has_room && !cut_reg && (rx_byte != CH_NUL) && (is_digit || is_alpha);
        idle_inc_ovf = (idle_reg == 8'hFF);
        idle_inc = idle_inc_ovf ? idle_reg : idle_reg + 8'd1;

        count_next    = count_reg;
        line_end_next = line_end_reg;
        idle_next     = idle_reg;
        cut_next      = cut_reg;
        prev_next     = prev_reg;
        aw_next       = aw_reg;
        keys_next     = keys_reg;
        fire          = 1'b0;
        timed_out     = !line_end_reg;

        if (step && cmd == CMD_BYTE) begin
            idle_next = 8'd0;
            if ((rx_byte == CH_LF) || (rx_byte == CH_CR))
                line_end_next = 1'b1;
            if (has_room) begin
                count_next = count_reg + CNT_W'(1);
                if (!cut_reg && rx_byte == CH_NUL)
                    cut_next = 1'b1;
            end
            if (kept) begin
                if (is_digit) begin
                    for (int k = 0; k < DIGIT_KEYS; k++) begin
                        if (keys_reg.seen[k] && !keys_reg.found[k]) begin
                            keys_next.found[k] = 1'b1;
                            keys_next.value[k] = 4'(rx_byte - CH_ZERO);
                        end
                    end
                end
                if (rx_byte == CH_A) keys_next.seen[KEY_A] = 1'b1;
                if (rx_byte == CH_O) begin
                    keys_next.seen[KEY_O] = 1'b1;
                    if (keys_reg.any_kept && prev_reg == CH_A) keys_next.seen[KEY_AO] = 1'b1;
                    if (aw_reg == AW_AUT) keys_next.seen[KEY_AUTO] = 1'b1;
                end
                if (rx_byte == CH_F) keys_next.seen[KEY_F] = 1'b1;
                if (rx_byte == CH_P) keys_next.seen[KEY_P] = 1'b1;
                if (rx_byte == CH_H) keys_next.seen[KEY_H] = 1'b1;
                if (rx_byte == CH_L) keys_next.seen[KEY_L] = 1'b1;
                if (rx_byte == CH_E && keys_reg.any_kept && prev_reg == CH_H)
                    keys_next.seen[KEY_HE] = 1'b1;
                if (rx_byte == CH_I && keys_reg.any_kept && prev_reg == CH_L)
                    keys_next.seen[KEY_LI] = 1'b1;
                priority if (rx_byte == CH_A)                 aw_next = AW_A;
                else if (aw_reg == AW_A && rx_byte == CH_U)   aw_next = AW_AU;
                else if (aw_reg == AW_AU && rx_byte == CH_T)  aw_next = AW_AUT;
                else                                          aw_next = AW_NONE;
                prev_next         = rx_byte;
                keys_next.any_kept = 1'b1;
            end
        end else if (step) begin
            idle_next = idle_inc;
            if (count_reg != '0) begin
                fire = line_end_reg ? (idle_inc > short_gap) : (idle_inc > long_gap);
            end
            if (fire) begin
                // line consumed: clear framing and trackers, timer keeps running
                count_next    = '0;
                line_end_next = 1'b0;
                cut_next      = 1'b0;
                prev_next     = 8'd0;
                aw_next       = AW_NONE;
                keys_next     = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            line_end_reg <= 1'b0;
            idle_reg     <= 8'd0;
            cut_reg      <= 1'b0;
            prev_reg     <= 8'd0;
            aw_reg       <= AW_NONE;
            keys_reg     <= '0;
        end else begin
            count_reg    <= count_next;
            line_end_reg <= line_end_next;
            idle_reg     <= idle_next;
            cut_reg      <= cut_next;
            prev_reg     <= prev_next;
            aw_reg       <= aw_next;
            keys_reg     <= keys_next;
        end
    end

endmodule

[src/cmdl_decoder.sv]
// Frame decode: applies the keyword snapshot to the actuator levels and
// builds the result item. Depends on cmdl_pkg.
module cmdl_decoder (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     fire,
    input  logic                     timed_out,
    input  cmdl_pkg::line_keys_t     keys,
    output cmdl_pkg::frame_result_t  result
);
    import cmdl_pkg::*;

    logic [NUM_ACT-1:0][3:0] levels_reg, levels_next;
    logic empty, ignored;
    logic [3:0] auto_key;

    // digit sets the level; no digit turns an on level off and any other level on
    function automatic logic [3:0] apply_key(input logic found, input logic [3:0] value,
                                             input logic [3:0] cur);
        logic [3:0] r;
        if (found) r = value;
        else       r = (cur == LEVEL_ON) ? LEVEL_OFF : LEVEL_ON;
        return r;
    endfunction

    always_comb begin
        levels_next = levels_reg;
        empty       = !keys.any_kept;
        ignored     = 1'b0;
        auto_key    = 4'(KEY_A);
        if (keys.seen[KEY_AUTO])    auto_key = 4'(KEY_AUTO);
        else if (keys.seen[KEY_AO]) auto_key = 4'(KEY_AO);
        if (!empty) begin
            priority if (keys.seen[KEY_A] && keys.seen[KEY_O]) begin
                levels_next[ACT_AUTO] = apply_key(keys.found[auto_key], keys.value[auto_key],
                                                  levels_reg[ACT_AUTO]);
            end else if (levels_reg[ACT_AUTO] == LEVEL_ON) begin
                ignored = 1'b1;
            end else begin
                if (keys.seen[KEY_F])
                    levels_next[ACT_FAN] = apply_key(keys.found[KEY_F], keys.value[KEY_F],
                                                     levels_reg[ACT_FAN]);
                if (keys.seen[KEY_P])
                    levels_next[ACT_PUMP] = apply_key(keys.found[KEY_P], keys.value[KEY_P],
                                                      levels_reg[ACT_PUMP]);
                if (keys.seen[KEY_H]) begin
                    if (keys.seen[KEY_HE])
                        levels_next[ACT_HEATER] = apply_key(keys.found[KEY_HE],
                            keys.value[KEY_HE], levels_reg[ACT_HEATER]);
                    else
                        levels_next[ACT_HEATER] = apply_key(keys.found[KEY_H],
                            keys.value[KEY_H], levels_reg[ACT_HEATER]);
                end
                if (keys.seen[KEY_L]) begin
                    if (keys.seen[KEY_LI])
                        levels_next[ACT_LIGHT] = apply_key(keys.found[KEY_LI],
                            keys.value[KEY_LI], levels_reg[ACT_LIGHT]);
                    else
                        levels_next[ACT_LIGHT] = apply_key(keys.found[KEY_L],
                            keys.value[KEY_L], levels_reg[ACT_LIGHT]);
                end
                if (keys.seen[KEY_A] && !keys.seen[KEY_AUTO] && !keys.seen[KEY_AO])
                    levels_next[ACT_ALARM] = apply_key(keys.found[KEY_A], keys.value[KEY_A],
                                                       levels_reg[ACT_ALARM]);
            end
        end
        result.frame_timed_out = timed_out;
        result.text_empty      = empty;
        result.ignored_in_auto = ignored;
        result.levels          = levels_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg <= '0;
        end else if (fire) begin
            levels_reg <= levels_next;
        end
    end

endmodule

[src/text_command_line_decoder.sv]
// Text command line decoder, top level.
// Input item register, config registers, result register; uses cmdl_pkg,
// cmdl_tracker and cmdl_decoder.
//
// Usage:
//   s_ channel: one transaction per received byte (s_tuser = 0, byte in
//   s_tdata) or per one millisecond tick (s_tuser = 1, s_tdata ignored).
//   m_ channel: one transaction for each tick that closes a line, carrying
//   the status flags and all six levels after that line.
//   cfg channel: index 0 writes the short gap, index 1 the long gap; other
//   indexes are ignored. cfg_ready is always high; write only while idle.
// An accepted item is held in the input register until it advances; its
// result, if any, is then registered in the output register for m_tvalid.
// Throughput: one item per cycle while no result stalls; the tracker and
// decoder update their state in one shallow combinational step per item.
// Stall: while a result waits on m_tready low, the input register holds its
// item and s_tready drops once that register is full; nothing is lost.
// Reset (aresetn low, synchronous): gaps return to 10 and 100, all levels,
// line state and the idle timer clear, both channels go empty.
module text_command_line_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] frame_timed_out, [1] text_empty, [2] ignored_in_auto,
    // [6:3] auto_level, [10:7] fan_level, [14:11] pump_level,
    // [18:15] heater_level, [22:19] light_level, [26:23] alarm_level, [31:27] zero
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import cmdl_pkg::*;

    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;
    logic [7:0] short_gap_reg, long_gap_reg;
    logic       m_valid_reg;
    logic [31:0] m_data_reg;

    logic          advance, fire, timed_out;
    line_keys_t    keys;
    frame_result_t result;

    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= s_tuser[0];
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_gap_reg <= SHORT_GAP_RESET;
            long_gap_reg  <= LONG_GAP_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_SHORT_GAP) short_gap_reg <= cfg_data;
            if (cfg_index == REG_LONG_GAP)  long_gap_reg  <= cfg_data;
        end
    end

    cmdl_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .cmd       (in_cmd_reg),
        .rx_byte   (in_byte_reg),
        .short_gap (short_gap_reg),
        .long_gap  (long_gap_reg),
        .fire      (fire),
        .timed_out (timed_out),
        .keys      (keys)
    );

    cmdl_decoder u_decoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .timed_out (timed_out),
        .keys      (keys),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= fire;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && fire) begin
            m_data_reg <= {5'd0,
                           result.levels[ACT_ALARM],
                           result.levels[ACT_LIGHT],
                           result.levels[ACT_HEATER],
                           result.levels[ACT_PUMP],
                           result.levels[ACT_FAN],
                           result.levels[ACT_AUTO],
                           result.ignored_in_auto,
                           result.text_empty,
                           result.frame_timed_out};
        end
    end

endmodule
